// File: src/cbu_pkg.sv
// shared constants, control struct and arc-tangent table for the compass bearing unit
// no dependencies; used by compass_bearing_unit
package cbu_pkg;

    // default sizing of the unit
    localparam int COORD_WIDTH_DEF   = 32;
    localparam int FRAC_BITS_DEF     = 8;
    localparam int CORDIC_STAGES_DEF = 16;

    // angle accumulator: degrees with 24 fraction bits
    localparam int ANG_FRAC  = 24;
    localparam int ANG_W     = 32;
    localparam int TABLE_LEN = 24;

    // cordic datapath: inputs normalized so the larger magnitude has its msb here
    localparam int NORM_MSB = 52;
    localparam int CORE_W   = 56;

    // whole-degree fields
    localparam int HEAD_W = 9;
    localparam int DEG_W  = 9;

    localparam int DEG_90  = 90;
    localparam int DEG_180 = 180;
    localparam int DEG_270 = 270;
    localparam int DEG_360 = 360;

    // plane selector codes
    localparam logic [1:0] PLANE_XY = 2'd0;
    localparam logic [1:0] PLANE_YZ = 2'd1;
    localparam logic [1:0] PLANE_XZ = 2'd2;

    // per-item control carried alongside the datapath
    typedef struct packed {
        logic              blank;   // unused plane code, result forced to zero
        logic              rel;     // relative bearing requested
        logic [HEAD_W-1:0] head;    // heading of the chosen plane
        logic              u_neg;
        logic              v_neg;
        logic              u_zero;
        logic              v_zero;
    } item_ctl_t;

    // atan(2^-i) in degrees, 24 fraction bits
    function automatic logic [ANG_W-1:0] atan_deg(input int idx);
        logic [ANG_W-1:0] r;
        case (idx)
            0:       r = 32'd754974720;
            1:       r = 32'd445687602;
            2:       r = 32'd235489089;
            3:       r = 32'd119537938;
            4:       r = 32'd60000934;
            5:       r = 32'd30029717;
            6:       r = 32'd15018523;
            7:       r = 32'd7509720;
            8:       r = 32'd3754917;
            9:       r = 32'd1877466;
            10:      r = 32'd938734;
            11:      r = 32'd469367;
            12:      r = 32'd234684;
            13:      r = 32'd117342;
            14:      r = 32'd58671;
            15:      r = 32'd29335;
            16:      r = 32'd14668;
            17:      r = 32'd7334;
            18:      r = 32'd3667;
            19:      r = 32'd1833;
            20:      r = 32'd917;
            21:      r = 32'd458;
            22:      r = 32'd229;
            23:      r = 32'd115;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// File: src/compass_bearing_unit.sv
// Registers from input item to result: s1, s2, s3, the cordic chain, p1, p2 and the output register.
// Throughput: one item per cycle; the whole pipeline advances together and holds
// while a result waits at the output register, one cordic iteration per stage.
// Reset: rst_n clears all valid bits asynchronously; payload registers are not reset.
// compass bearing unit: plane projection, normalize, pipelined cordic, quadrant fixup
// depends on cbu_pkg
module compass_bearing_unit #(
    parameter int COORD_WIDTH   = cbu_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS     = cbu_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = cbu_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [COORD_WIDTH-1:0]        observer_x,
    input  logic signed [COORD_WIDTH-1:0]        observer_y,
    input  logic signed [COORD_WIDTH-1:0]        observer_z,
    input  logic signed [COORD_WIDTH-1:0]        target_x,
    input  logic signed [COORD_WIDTH-1:0]        target_y,
    input  logic signed [COORD_WIDTH-1:0]        target_z,
    input  logic [1:0]                           opcode,
    input  logic                                 relative_mode,
    input  logic [cbu_pkg::HEAD_W-1:0]           heading_x,
    input  logic [cbu_pkg::HEAD_W-1:0]           heading_y,
    input  logic [cbu_pkg::HEAD_W-1:0]           heading_z,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [cbu_pkg::DEG_W+FRAC_BITS-1:0]  bearing_deg
);

    localparam int DW    = COORD_WIDTH + 1;
    localparam int BW    = cbu_pkg::DEG_W + FRAC_BITS;
    localparam int SH_W  = $clog2(cbu_pkg::NORM_MSB + 1);
    localparam int RS    = cbu_pkg::ANG_FRAC - FRAC_BITS;
    localparam int CW    = cbu_pkg::CORE_W;
    localparam int AW    = cbu_pkg::ANG_W;
    localparam int NS    = CORDIC_STAGES;

    localparam logic [BW-1:0] FULL_TURN = BW'(cbu_pkg::DEG_360) << FRAC_BITS;
    localparam logic [BW-1:0] HALF_TURN = BW'(cbu_pkg::DEG_180) << FRAC_BITS;
    localparam logic [BW-1:0] QTR_TURN  = BW'(cbu_pkg::DEG_90) << FRAC_BITS;
    localparam logic [BW-1:0] TQ_TURN   = BW'(cbu_pkg::DEG_270) << FRAC_BITS;
    localparam logic signed [AW-1:0] ANG_LIM =
        AW'(cbu_pkg::DEG_90) << cbu_pkg::ANG_FRAC;
    localparam logic [AW-1:0] ANG_HALF_LSB = AW'(1) << (RS - 1);
    localparam logic signed [10:0] WRAP_1 = 11'sd360;
    localparam logic signed [10:0] WRAP_2 = 11'sd720;

    // pipeline advances as one unit unless a result is held at the output
    logic adv;
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    // ---------------- stage 1: plane select and difference ----------------
    logic signed [DW-1:0] s1_du_next, s1_dv_next;
    cbu_pkg::item_ctl_t   s1_ctl_next;
    logic signed [DW-1:0] s1_du_reg, s1_dv_reg;
    cbu_pkg::item_ctl_t   s1_ctl_reg;
    logic                 s1_valid_reg;

    always_comb
    begin
        logic signed [COORD_WIDTH-1:0] fu, fv, tu, tv;
        fu = observer_x;
        fv = observer_y;
        tu = target_x;
        tv = target_y;
        s1_ctl_next        = '0;
        s1_ctl_next.rel    = relative_mode;
        unique case (opcode)
            cbu_pkg::PLANE_XY:
            begin
                s1_ctl_next.head = heading_x;
            end
            cbu_pkg::PLANE_YZ:
            begin
                fu = observer_y;
                fv = observer_z;
                tu = target_y;
                tv = target_z;
                s1_ctl_next.head = heading_y;
            end
            cbu_pkg::PLANE_XZ:
            begin
                fv = observer_z;
                tv = target_z;
                s1_ctl_next.head = heading_z;
            end
            default:
            begin
                s1_ctl_next.blank = 1'b1;
            end
        endcase
        s1_du_next = DW'(tu) - DW'(fu);
        s1_dv_next = DW'(tv) - DW'(fv);
    end

    // ---------------- stage 2: magnitudes and signs ----------------
    logic [DW-1:0]      s2_au_next, s2_av_next;
    cbu_pkg::item_ctl_t s2_ctl_next;
    logic [DW-1:0]      s2_au_reg, s2_av_reg;
    cbu_pkg::item_ctl_t s2_ctl_reg;
    logic               s2_valid_reg;

    always_comb
    begin
        s2_ctl_next        = s1_ctl_reg;
        s2_ctl_next.u_neg  = s1_du_reg[DW-1];
        s2_ctl_next.v_neg  = s1_dv_reg[DW-1];
        s2_ctl_next.u_zero = (s1_du_reg == '0);
        s2_ctl_next.v_zero = (s1_dv_reg == '0);
        s2_au_next = s1_du_reg[DW-1] ? DW'(-s1_du_reg) : DW'(s1_du_reg);
        s2_av_next = s1_dv_reg[DW-1] ? DW'(-s1_dv_reg) : DW'(s1_dv_reg);
    end

    // ---------------- stage 3: leading one search for normalization ----------------
    logic [SH_W-1:0]    s3_sh_next;
    logic [DW-1:0]      s3_a_reg, s3_b_reg;
    logic [SH_W-1:0]    s3_sh_reg;
    cbu_pkg::item_ctl_t s3_ctl_reg;
    logic               s3_valid_reg;

    always_comb
    begin
        logic [DW-1:0]   mx;
        logic [SH_W-1:0] msb;
        mx  = (s2_au_reg > s2_av_reg) ? s2_au_reg : s2_av_reg;
        msb = '0;
        for (int i = 0; i < DW; i++)
        begin
            if (mx[i])
            begin
                msb = SH_W'(i);
            end
        end
        s3_sh_next = SH_W'(cbu_pkg::NORM_MSB) - msb;
    end

    // ---------------- stage 4 and cordic chain ----------------
    // index 0 holds the normalized vector, index i+1 the result of iteration i
    logic signed [CW-1:0] c_x_reg [0:NS];
    logic signed [CW-1:0] c_y_reg [0:NS];
    logic signed [AW-1:0] c_z_reg [0:NS];
    cbu_pkg::item_ctl_t   c_ctl_reg [0:NS];
    logic                 c_valid_reg [0:NS];

    logic signed [CW-1:0] c0_x_next, c0_y_next;
    assign c0_x_next = CW'(s3_b_reg) << s3_sh_reg;
    assign c0_y_next = CW'(s3_a_reg) << s3_sh_reg;

    // ---------------- post stages ----------------
    logic [BW-1:0]      p1_q_next, p1_q_reg;
    cbu_pkg::item_ctl_t p1_ctl_reg;
    logic               p1_valid_reg;
    logic [BW-1:0]      p2_bearing_next, p2_bearing_reg;
    cbu_pkg::item_ctl_t p2_ctl_reg;
    logic               p2_valid_reg;
    logic [BW-1:0]      out_bearing_next, out_bearing_reg;
    logic               out_valid_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            c_valid_reg[0] <= 1'b0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            c_valid_reg[0] <= s3_valid_reg;
            p1_valid_reg  <= c_valid_reg[NS];
            p2_valid_reg  <= p1_valid_reg;
            out_valid_reg <= p2_valid_reg;
        end
    end

    // front stage payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_du_reg    <= s1_du_next;
            s1_dv_reg    <= s1_dv_next;
            s1_ctl_reg   <= s1_ctl_next;
            s2_au_reg    <= s2_au_next;
            s2_av_reg    <= s2_av_next;
            s2_ctl_reg   <= s2_ctl_next;
            s3_a_reg     <= s2_au_reg;
            s3_b_reg     <= s2_av_reg;
            s3_sh_reg    <= s3_sh_next;
            s3_ctl_reg   <= s2_ctl_reg;
            c_x_reg[0]   <= c0_x_next;
            c_y_reg[0]   <= c0_y_next;
            c_z_reg[0]   <= '0;
            c_ctl_reg[0] <= s3_ctl_reg;
        end
    end

    // one vectoring iteration per stage
    for (genvar gi = 0; gi < NS; gi++)
    begin : g_cordic
        logic signed [CW-1:0] xs, ys, x_next, y_next;
        logic signed [AW-1:0] ang, z_next;

        assign xs  = c_x_reg[gi] >>> gi;
        assign ys  = c_y_reg[gi] >>> gi;
        assign ang = signed'(cbu_pkg::atan_deg(gi));

        // rotate toward the x axis according to the sign of y
        always_comb
        begin
            if (!c_y_reg[gi][CW-1])
            begin
                x_next = c_x_reg[gi] + ys;
                y_next = c_y_reg[gi] - xs;
                z_next = c_z_reg[gi] + ang;
            end
            else
            begin
                x_next = c_x_reg[gi] - ys;
                y_next = c_y_reg[gi] + xs;
                z_next = c_z_reg[gi] - ang;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                c_valid_reg[gi+1] <= 1'b0;
            end
            else if (adv)
            begin
                c_valid_reg[gi+1] <= c_valid_reg[gi];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                c_x_reg[gi+1]   <= x_next;
                c_y_reg[gi+1]   <= y_next;
                c_z_reg[gi+1]   <= z_next;
                c_ctl_reg[gi+1] <= c_ctl_reg[gi];
            end
        end
    end

    // clamp to the first quadrant and round to the output fraction
    always_comb
    begin
        logic signed [AW-1:0] zc;
        logic [AW-1:0]        zr;
        zc = c_z_reg[NS];
        if (zc < 0)
        begin
            zc = '0;
        end
        else if (zc > ANG_LIM)
        begin
            zc = ANG_LIM;
        end
        zr = unsigned'(zc) + ANG_HALF_LSB;
        p1_q_next = BW'(zr >> RS);
    end

    // quadrant fixup and axis cases
    always_comb
    begin
        logic [BW-1:0] b;
        if (p1_ctl_reg.blank || (p1_ctl_reg.u_zero && p1_ctl_reg.v_zero))
        begin
            b = '0;
        end
        else if (p1_ctl_reg.v_zero)
        begin
            b = p1_ctl_reg.u_neg ? TQ_TURN : QTR_TURN;
        end
        else if (p1_ctl_reg.u_zero)
        begin
            b = p1_ctl_reg.v_neg ? HALF_TURN : '0;
        end
        else if (!p1_ctl_reg.u_neg && !p1_ctl_reg.v_neg)
        begin
            b = p1_q_reg;
        end
        else if (!p1_ctl_reg.u_neg)
        begin
            b = HALF_TURN - p1_q_reg;
        end
        else if (!p1_ctl_reg.v_neg)
        begin
            b = FULL_TURN - p1_q_reg;
        end
        else
        begin
            b = HALF_TURN + p1_q_reg;
        end
        // a bearing that rounds to a full turn wraps to zero
        p2_bearing_next = (b >= FULL_TURN) ? '0 : b;
    end

    // relative mode: whole degrees minus heading, wrapped into one turn
    always_comb
    begin
        logic signed [10:0] d;
        d = signed'({2'b00, p2_bearing_reg[BW-1:FRAC_BITS]})
            - signed'({2'b00, p2_ctl_reg.head});
        if (d < -WRAP_1)
        begin
            d = d + WRAP_2;
        end
        else if (d < 0)
        begin
            d = d + WRAP_1;
        end
        if (p2_ctl_reg.rel && !p2_ctl_reg.blank)
        begin
            out_bearing_next = BW'(d[cbu_pkg::DEG_W-1:0]) << FRAC_BITS;
        end
        else
        begin
            out_bearing_next = p2_bearing_reg;
        end
    end

    // back stage payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_q_reg        <= p1_q_next;
            p1_ctl_reg      <= c_ctl_reg[NS];
            p2_bearing_reg  <= p2_bearing_next;
            p2_ctl_reg      <= p1_ctl_reg;
            out_bearing_reg <= out_bearing_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign bearing_deg = out_bearing_reg;

`ifndef SYNTHESIS
    // a delivered bearing never reaches a full turn
    a_bearing_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (bearing_deg < FULL_TURN))
        else $error("bearing at or above full turn");

    // relative results carry no fraction
    a_rel_whole: assert property (@(posedge clk) disable iff (!rst_n)
        (p2_valid_reg && p2_ctl_reg.rel && adv) |=> (bearing_deg[FRAC_BITS-1:0] == '0))
        else $error("relative bearing has a fraction");

    // the cordic x term stays positive for a true quadrant case
    a_cordic_x_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (c_valid_reg[NS] && !c_ctl_reg[NS].u_zero && !c_ctl_reg[NS].v_zero
         && !c_ctl_reg[NS].blank) |-> !c_x_reg[NS][CW-1])
        else $error("cordic x went negative");
`endif

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// self-checking bench for compass_bearing_unit: directed corner items, then random point pairs
// depends on cbu_pkg and compass_bearing_unit; bearings predicted by an in-bench cordic model
module tb_top;

    import cbu_pkg::*;

    localparam int FRAC   = FRAC_BITS_DEF;
    localparam int BEAR_W = DEG_W + FRAC_BITS_DEF;
    localparam int CW     = COORD_WIDTH_DEF;

    // plane code with no plane behind it
    localparam logic [1:0] PLANE_NONE = 2'd3;

    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};

    localparam int HOLD_AFTER   = 300;  // items accepted before the long output hold
    localparam int HOLD_CYCLES  = 80;
    localparam int QUIET_TAIL   = 150;  // last items sent with no idling

    // one point pair with its plane and headings
    typedef struct packed {
        logic signed [CW-1:0] ox;
        logic signed [CW-1:0] oy;
        logic signed [CW-1:0] oz;
        logic signed [CW-1:0] tx;
        logic signed [CW-1:0] ty;
        logic signed [CW-1:0] tz;
        logic [1:0]           plane;
        logic                 rel;
        logic [HEAD_W-1:0]    hx;
        logic [HEAD_W-1:0]    hy;
        logic [HEAD_W-1:0]    hz;
    } point_pair_t;

    // atan(2^-i) in degrees, 24 fraction bits
    longint atan_q24 [0:15] = '{754974720, 445687602, 235489089, 119537938,
                                60000934, 30029717, 15018523, 7509720,
                                3754917, 1877466, 938734, 469367,
                                234684, 117342, 58671, 29335};

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic signed [CW-1:0] observer_x = '0;
    logic signed [CW-1:0] observer_y = '0;
    logic signed [CW-1:0] observer_z = '0;
    logic signed [CW-1:0] target_x = '0;
    logic signed [CW-1:0] target_y = '0;
    logic signed [CW-1:0] target_z = '0;
    logic [1:0]           opcode = '0;
    logic                 relative_mode = 1'b0;
    logic [HEAD_W-1:0]    heading_x = '0;
    logic [HEAD_W-1:0]    heading_y = '0;
    logic [HEAD_W-1:0]    heading_z = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [BEAR_W-1:0]    bearing_deg;

    point_pair_t       pending_pairs [$];
    logic [BEAR_W-1:0] bearing_expect_q [$];
    point_pair_t       cur_pair;
    logic [BEAR_W-1:0] want_bearing;
    bit                pair_taken = 1'b0;
    bit                sends_done = 1'b0;
    bit                long_hold_done = 1'b0;
    int unsigned       pairs_queued = 0;
    int unsigned       pairs_accepted = 0;
    int unsigned       fail_count = 0;
    int                tx_gap_left = 0;
    int                rx_gap_left = 0;
    int                long_hold_left = 0;

    compass_bearing_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .observer_x    (observer_x),
        .observer_y    (observer_y),
        .observer_z    (observer_z),
        .target_x      (target_x),
        .target_y      (target_y),
        .target_z      (target_z),
        .opcode        (opcode),
        .relative_mode (relative_mode),
        .heading_x     (heading_x),
        .heading_y     (heading_y),
        .heading_z     (heading_z),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .bearing_deg   (bearing_deg)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // bearing of target seen from observer, with relative heading applied
    function automatic logic [BEAR_W-1:0] predict_bearing(input point_pair_t p);
        longint            fu, fv, tu, tv, du, dv, x, y, z, xs, ys, bearing, d;
        longint unsigned   au, av, mx;
        longint            head;
        longint            full, half;
        int                i;
        full = longint'(DEG_360) << FRAC;
        half = longint'(DEG_180) << FRAC;
        case (p.plane)
            PLANE_XY:
            begin
                fu = p.ox; fv = p.oy; tu = p.tx; tv = p.ty; head = p.hx;
            end
            PLANE_YZ:
            begin
                fu = p.oy; fv = p.oz; tu = p.ty; tv = p.tz; head = p.hy;
            end
            PLANE_XZ:
            begin
                fu = p.ox; fv = p.oz; tu = p.tx; tv = p.tz; head = p.hz;
            end
            default:
            begin
                return '0;
            end
        endcase
        du = tu - fu;
        dv = tv - fv;
        au = (du < 0) ? longint'(-du) : du;
        av = (dv < 0) ? longint'(-dv) : dv;

        if (du == 0 && dv == 0)
            bearing = 0;
        else if (dv == 0)
            bearing = (du > 0) ? (longint'(DEG_90) << FRAC) : (longint'(DEG_270) << FRAC);
        else if (du == 0)
            bearing = (dv > 0) ? 0 : half;
        else
        begin
            // normalize, then vector (b, a) onto the x axis
            mx = (au > av) ? au : av;
            while (mx < (64'd1 << NORM_MSB))
            begin
                mx = mx << 1;
                au = au << 1;
                av = av << 1;
            end
            x = av;
            y = au;
            z = 0;
            for (i = 0; i < CORDIC_STAGES_DEF; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0)
                begin
                    x = x + ys; y = y - xs; z = z + atan_q24[i];
                end
                else
                begin
                    x = x - ys; y = y + xs; z = z - atan_q24[i];
                end
            end
            if (z < 0)
                z = 0;
            if (z > (longint'(DEG_90) << ANG_FRAC))
                z = longint'(DEG_90) << ANG_FRAC;
            z = (z + (longint'(1) << (ANG_FRAC - FRAC - 1))) >>> (ANG_FRAC - FRAC);
            // quadrant fixup
            if (du > 0 && dv > 0)
                bearing = z;
            else if (du > 0)
                bearing = half - z;
            else if (dv > 0)
                bearing = full - z;
            else
                bearing = half + z;
            if (bearing >= full)
                bearing = 0;
        end

        if (p.rel)
        begin
            d = (bearing >>> FRAC) - head;
            while (d < 0)
                d = d + DEG_360;
            bearing = d << FRAC;
        end
        return bearing[BEAR_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [BEAR_W-1:0] want,
                                   input logic [BEAR_W-1:0] got);
        fail_count++;
        $display("MISMATCH %s: expected %0d got %0d at %0t", what, want, got, $realtime);
    endtask

    task automatic add_pair(input logic signed [CW-1:0] ox, input logic signed [CW-1:0] oy,
                            input logic signed [CW-1:0] oz, input logic signed [CW-1:0] tx,
                            input logic signed [CW-1:0] ty, input logic signed [CW-1:0] tz,
                            input logic [1:0] plane, input logic rel,
                            input int hx, input int hy, input int hz);
        point_pair_t p;
        p.ox = ox; p.oy = oy; p.oz = oz;
        p.tx = tx; p.ty = ty; p.tz = tz;
        p.plane = plane;
        p.rel = rel;
        p.hx = hx[HEAD_W-1:0];
        p.hy = hy[HEAD_W-1:0];
        p.hz = hz[HEAD_W-1:0];
        pending_pairs.push_back(p);
        pairs_queued++;
    endtask

    // coordinate drawn from a mix of full range, small, medium and extreme values
    function automatic logic signed [CW-1:0] pick_coord();
        int pick;
        int t;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return $urandom;
        else if (pick < 6)
        begin
            t = $urandom_range(0, 16);
            return t - 8;
        end
        else if (pick < 8)
        begin
            t = $urandom_range(0, 200000);
            return t - 100000;
        end
        else
        begin
            case ($urandom_range(0, 4))
                0:       return C_MIN;
                1:       return C_MAX;
                2:       return '0;
                3:       return -1;
                default: return 1;
            endcase
        end
    endfunction

    // target component: same as observer, a near neighbor, or independent
    function automatic logic signed [CW-1:0] pick_target(input logic signed [CW-1:0] obs);
        int pick;
        int t;
        pick = $urandom_range(0, 7);
        if (pick < 2)
            return obs;
        else if (pick < 4)
        begin
            t = $urandom_range(0, 6);
            return obs + (t - 3);
        end
        else
            return pick_coord();
    endfunction

    function automatic int pick_heading();
        if ($urandom_range(0, 19) < 17)
            return $urandom_range(0, DEG_360);
        return $urandom_range(DEG_360 + 1, (1 << HEAD_W) - 1);
    endfunction

    task automatic add_random_pairs(input int count);
        logic signed [CW-1:0] ox, oy, oz;
        logic [1:0]           plane;
        int                   n;
        for (n = 0; n < count; n++)
        begin
            ox = pick_coord();
            oy = pick_coord();
            oz = pick_coord();
            plane = ($urandom_range(0, 19) == 0) ? PLANE_NONE : 2'($urandom_range(0, 2));
            add_pair(ox, oy, oz, pick_target(ox), pick_target(oy), pick_target(oz),
                     plane, 1'($urandom_range(0, 1)),
                     pick_heading(), pick_heading(), pick_heading());
        end
    endtask

    // no idling once the last stretch of items is being sent
    function automatic bit quiet_tail();
        return sends_done && (pending_pairs.size() < QUIET_TAIL);
    endfunction

    task automatic wait_drained();
        while (pairs_accepted != pairs_queued || bearing_expect_q.size() != 0)
            @(negedge clk);
    endtask

    // stimulus and end of run
    initial
    begin
        // axis-aligned, coincident and quadrant cases
        add_pair(0, 0, 0, 0, 0, 0, PLANE_XY, 1'b0, 0, 0, 0);
        add_pair(0, 0, 0, 5, 0, 0, PLANE_XY, 1'b0, 0, 0, 0);
        add_pair(0, 0, 0, -5, 0, 0, PLANE_XY, 1'b0, 0, 0, 0);
        add_pair(0, 0, 0, 0, 7, 0, PLANE_XY, 1'b0, 0, 0, 0);
        add_pair(0, 0, 0, 0, -7, 0, PLANE_XY, 1'b0, 0, 0, 0);
        add_pair(0, 0, 0, 0, 100, 100, PLANE_YZ, 1'b0, 0, 0, 0);
        add_pair(0, 0, 0, 0, 3, -4, PLANE_YZ, 1'b0, 0, 0, 0);
        add_pair(0, 0, 0, -4, 0, 3, PLANE_XZ, 1'b0, 0, 0, 0);
        // widest differences in both directions
        add_pair(C_MAX, 0, C_MAX, C_MIN, 0, C_MIN, PLANE_XZ, 1'b0, 0, 0, 0);
        add_pair(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, PLANE_XY, 1'b0, 0, 0, 0);
        add_pair(C_MAX, 1, 0, C_MIN, 0, 0, PLANE_XY, 1'b0, 0, 0, 0);
        add_pair(0, 0, 0, C_MAX, 1, 0, PLANE_XY, 1'b0, 0, 0, 0);
        // tiny negative u against huge v rounds up to a full turn
        add_pair(0, C_MIN, 0, -1, C_MAX, 0, PLANE_XY, 1'b0, 0, 0, 0);
        // relative mode, headings at zero, full turn and above range
        add_pair(0, 0, 0, 3, 4, 0, PLANE_XY, 1'b1, 0, 0, 0);
        add_pair(0, 0, 0, 3, 4, 0, PLANE_XY, 1'b1, 360, 0, 0);
        add_pair(0, 0, 0, 3, 4, 0, PLANE_XY, 1'b1, 511, 0, 0);
        add_pair(0, 0, 0, 0, -3, -4, PLANE_YZ, 1'b1, 0, 100, 0);
        add_pair(9, 9, 9, 9, 9, 9, PLANE_XZ, 1'b1, 0, 0, 359);
        add_pair(0, 0, 0, -8, 0, 0, PLANE_XY, 1'b1, 270, 0, 0);
        // unused plane code in both modes
        add_pair(1, 2, 3, 40, 50, 60, PLANE_NONE, 1'b0, 10, 20, 30);
        add_pair(1, 2, 3, 40, 50, 60, PLANE_NONE, 1'b1, 200, 200, 200);
        add_pair(-1, -1, -1, 0, 0, 0, PLANE_XZ, 1'b0, 0, 0, 0);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // sender pauses until every result is back
        wait_drained();
        add_random_pairs(900);
        wait_drained();
        add_random_pairs(750);
        sends_done = 1'b1;
        wait_drained();
        repeat (40) @(negedge clk);

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    // input driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || pair_taken)
            begin
                pair_taken = 1'b0;
                if (tx_gap_left > 0)
                begin
                    tx_gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_pairs.size() == 0)
                    in_valid <= 1'b0;
                else if (!quiet_tail() && $urandom_range(0, 7) == 0)
                begin
                    tx_gap_left = $urandom_range(0, 2);
                    in_valid <= 1'b0;
                end
                else
                begin
                    cur_pair = pending_pairs.pop_front();
                    in_valid      <= 1'b1;
                    observer_x    <= cur_pair.ox;
                    observer_y    <= cur_pair.oy;
                    observer_z    <= cur_pair.oz;
                    target_x      <= cur_pair.tx;
                    target_y      <= cur_pair.ty;
                    target_z      <= cur_pair.tz;
                    opcode        <= cur_pair.plane;
                    relative_mode <= cur_pair.rel;
                    heading_x     <= cur_pair.hx;
                    heading_y     <= cur_pair.hy;
                    heading_z     <= cur_pair.hz;
                end
            end
        end
    end

    // output ready: random short stalls plus one long hold to back up the pipeline
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!long_hold_done && pairs_accepted >= HOLD_AFTER)
            begin
                long_hold_done = 1'b1;
                long_hold_left = HOLD_CYCLES - 1;
                out_ready <= 1'b0;
            end
            else if (long_hold_left > 0)
            begin
                long_hold_left--;
                out_ready <= 1'b0;
            end
            else if (rx_gap_left > 0)
            begin
                rx_gap_left--;
                out_ready <= 1'b0;
            end
            else if (!quiet_tail() && $urandom_range(0, 7) == 0)
            begin
                rx_gap_left = $urandom_range(0, 2);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // monitor: check results first, then record the accepted item
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (bearing_expect_q.size() == 0)
                    report_mismatch("result with no item pending", '0, bearing_deg);
                else
                begin
                    want_bearing = bearing_expect_q.pop_front();
                    if (bearing_deg !== want_bearing)
                        report_mismatch("bearing_deg", want_bearing, bearing_deg);
                end
            end
            if (in_valid && in_ready)
            begin
                bearing_expect_q.push_back(predict_bearing(cur_pair));
                pair_taken = 1'b1;
                pairs_accepted++;
            end
        end
    end

endmodule
